>>> hw/rtl/memo_payload_decoder_defines.svh
// ----------------------------------------------------------------------------
// Memo payload decoder: assertion macros
// Concurrent checks clocked on clk and disabled during rst. Define
// NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MEMO_PAYLOAD_DECODER_DEFINES_SVH
`define MEMO_PAYLOAD_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property at every rising clock edge outside reset
`define MPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset
`define MPD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MPD_ASSERT(lbl, prop, msg)
`define MPD_NEVER(lbl, expr, msg)
`endif

`endif

>>> hw/rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// Memo payload decoder package
// Codes, character constants, shared types and the nibble-pair helper.
// ----------------------------------------------------------------------------
package mpd_pkg;

  // Input actions
  typedef enum logic [1:0] {
    ACT_FIRST = 2'd0,
    ACT_CONT  = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Decoder phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_FIRST  = 4'd1,
    PH_TLO    = 4'd2,
    PH_THI    = 4'd3,
    PH_F2DATA = 4'd4,
    PH_F2HI   = 4'd5,
    PH_F1DATA = 4'd6,
    PH_F1LO   = 4'd7,
    PH_F1LIT  = 4'd8,
    PH_F1STAR = 4'd9,
    PH_CHECK  = 4'd10,
    PH_DONE   = 4'd11
  } phase_t;

  // Operations handed to the output stage
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TABLE   = 2'd1,
    OP_VERDICT = 2'd2,
    OP_FAIL    = 2'd3
  } op_code_t;

  localparam int unsigned TABLE_SIZE   = 203;
  localparam int unsigned CHECK_DIGITS = 5;
  localparam int unsigned CHECK_W      = 17;

  localparam logic [7:0] CODE_END2   = 8'd33;
  localparam logic [7:0] NIB_OFFSET  = 8'd35;
  localparam logic [7:0] CODE_TABLE  = 8'd51;
  localparam logic [7:0] CODE_FORMAT2 = 8'd254;
  localparam logic [7:0] CHAR_TILDE  = 8'h7E;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] HEX_ADJ     = 8'd10 - CHAR_LOW_A;

  // Classified input item
  typedef struct packed {
    action_t    act;
    logic [7:0] ch;
    logic [7:0] hex;
    logic       is_digit;
  } cmd_t;

  // Operation from the sequencer to the output stage
  typedef struct packed {
    logic               valid;
    op_code_t           code;
    logic [7:0]         data;
    logic [CHECK_W-1:0] check;
    logic               clr;
  } res_t;

  // Offset-35 nibble pair, low character first
  function automatic logic [7:0] pair35(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] l;
    logic [7:0] h;
    l = lo - NIB_OFFSET;
    h = hi - NIB_OFFSET;
    return l | {h[3:0], 4'b0000};
  endfunction

endpackage

>>> hw/rtl/mpd_front.sv
// ----------------------------------------------------------------------------
// Memo payload decoder front end
// Classifies each incoming character: digit test and hex nibble value.
// ----------------------------------------------------------------------------
module mpd_front (
  input  logic [1:0]   action,
  input  logic [7:0]   in_char,
  output mpd_pkg::cmd_t cmd
);
  import mpd_pkg::*;

  logic digit;

  // Classify the character
  assign digit = in_char inside {[CHAR_ZERO:CHAR_NINE]};

  always_comb begin
    cmd.act      = action_t'(action);
    cmd.ch       = in_char;
    cmd.is_digit = digit;
    cmd.hex      = digit ? (in_char - CHAR_ZERO) : (in_char + HEX_ADJ);
  end

endmodule

>>> hw/rtl/mpd_queue.sv
// ----------------------------------------------------------------------------
// Memo payload decoder command queue
// Short FIFO of classified transactions between front end and sequencer.
// ----------------------------------------------------------------------------
`include "memo_payload_decoder_defines.svh"

module mpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          full,
  input  mpd_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output mpd_pkg::cmd_t pop_data
);
  import mpd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  assign full      = (count == CW'(DEPTH));
  assign push      = push_valid && !full;
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `MPD_NEVER(a_count_bound, count > CW'(DEPTH), "queue count above depth")
  `MPD_NEVER(a_pop_empty, pop && !pop_valid, "pop from empty queue")
  `MPD_ASSERT(a_count_up, (push && !pop) |=> (count == $past(count) + 1'b1), "count missed push")

endmodule

>>> hw/rtl/mpd_back.sv
// ----------------------------------------------------------------------------
// Memo payload decoder sequencer
// Runs the part state machine on each transaction, loads and reads the
// format-2 lookup table, and issues operations to the output stage.
// ----------------------------------------------------------------------------
`include "memo_payload_decoder_defines.svh"

module mpd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mpd_pkg::cmd_t cmd,
  output logic          q_pop,
  input  logic          out_ready,
  output mpd_pkg::res_t res,
  output logic [7:0]    rd_data
);
  import mpd_pkg::*;

  phase_t             phase, phase_next;
  logic               format_two, format_two_next;
  logic [7:0]         table_index, table_index_next;
  logic [7:0]         pending_nibble, pending_nibble_next;
  logic [CHECK_W-1:0] check_value, check_value_next;
  logic [2:0]         digit_count, digit_count_next;
  logic               digits_stopped, digits_stopped_next;
  logic               pend_clr, pend_clr_next;

  logic [7:0]         special_table [TABLE_SIZE];
  logic               wr_en;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [7:0]         rd_addr;

  logic               fire;
  logic [7:0]         ch;
  logic [2:0]         dc_inc;
  logic               take_digit;
  logic [CHECK_W-1:0] check_step;
  logic               check_last;
  logic [7:0]         idx_inc;

  assign fire  = q_valid && out_ready;
  assign q_pop = fire;
  assign ch    = cmd.ch;

  // Checksum digit step: value * 10 + digit
  assign dc_inc     = digit_count + 3'd1;
  assign take_digit = !digits_stopped && cmd.is_digit;
  assign check_step = {check_value[CHECK_W-4:0], 3'b000} + {check_value[CHECK_W-2:0], 1'b0}
                      + CHECK_W'(cmd.hex[3:0]);
  assign check_last = (dc_inc >= 3'(CHECK_DIGITS));
  assign idx_inc    = table_index + 8'd1;
  assign rd_addr    = ch - CODE_TABLE;
  assign wr_data    = pair35(pending_nibble, ch);

  // Next state
  always_comb begin
    phase_next          = phase;
    format_two_next     = format_two;
    table_index_next    = table_index;
    pending_nibble_next = pending_nibble;
    check_value_next    = check_value;
    digit_count_next    = digit_count;
    digits_stopped_next = digits_stopped;
    pend_clr_next       = res.valid ? 1'b0 : pend_clr;
    if (fire) begin
      case (cmd.act)
        ACT_FIRST, ACT_CONT: begin
          pending_nibble_next = '0;
          check_value_next    = '0;
          digit_count_next    = '0;
          digits_stopped_next = 1'b0;
          pend_clr_next       = 1'b1;
          if (cmd.act == ACT_FIRST) begin
            phase_next = PH_FIRST;
          end else begin
            phase_next = format_two ? PH_F2DATA : PH_F1DATA;
          end
        end
        ACT_END: begin
          if (phase != PH_IDLE && phase != PH_DONE) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          case (phase)
            PH_FIRST, PH_F1DATA: begin
              if (phase == PH_FIRST && ch == CODE_FORMAT2) begin
                format_two_next  = 1'b1;
                table_index_next = '0;
                phase_next       = PH_TLO;
              end else begin
                if (phase == PH_FIRST) begin
                  format_two_next = 1'b0;
                end
                if (ch == CHAR_STAR) begin
                  phase_next = PH_F1STAR;
                end else if (ch == CHAR_TILDE) begin
                  phase_next = PH_F1LIT;
                end else begin
                  pending_nibble_next = {cmd.hex[3:0], 4'b0000};
                  phase_next          = PH_F1LO;
                end
              end
            end
            PH_TLO: begin
              pending_nibble_next = ch;
              phase_next          = PH_THI;
            end
            PH_THI: begin
              table_index_next = idx_inc;
              phase_next       = (idx_inc >= 8'(TABLE_SIZE)) ? PH_F2DATA : PH_TLO;
            end
            PH_F2DATA: begin
              if (ch == CODE_END2) begin
                phase_next          = PH_CHECK;
                check_value_next    = '0;
                digit_count_next    = '0;
                digits_stopped_next = 1'b0;
              end else if (ch >= CODE_TABLE) begin
                if (rd_addr >= 8'(TABLE_SIZE)) begin
                  phase_next = PH_DONE;
                end
              end else begin
                pending_nibble_next = ch;
                phase_next          = PH_F2HI;
              end
            end
            PH_F2HI: phase_next = PH_F2DATA;
            PH_F1LO: phase_next = PH_F1DATA;
            PH_F1LIT: begin
              if (ch == CHAR_TILDE) begin
                phase_next = PH_F1DATA;
              end
            end
            PH_F1STAR: begin
              if (ch == CHAR_STAR) begin
                phase_next          = PH_CHECK;
                check_value_next    = '0;
                digit_count_next    = '0;
                digits_stopped_next = 1'b0;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_CHECK: begin
              if (take_digit) begin
                check_value_next = check_step;
              end else begin
                digits_stopped_next = 1'b1;
              end
              digit_count_next = dc_inc;
              if (check_last) begin
                phase_next = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  // Operations and table access
  always_comb begin
    res.valid = 1'b0;
    res.code  = OP_BYTE;
    res.data  = '0;
    res.check = check_value;
    res.clr   = pend_clr;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    if (fire) begin
      case (cmd.act)
        ACT_END: begin
          if (phase == PH_CHECK) begin
            res.valid = 1'b1;
            res.code  = OP_VERDICT;
          end else if (phase != PH_IDLE && phase != PH_DONE) begin
            res.valid = 1'b1;
            res.code  = OP_FAIL;
          end
        end
        ACT_DATA: begin
          case (phase)
            PH_THI: wr_en = (table_index < 8'(TABLE_SIZE));
            PH_F2DATA: begin
              if (ch != CODE_END2 && ch >= CODE_TABLE) begin
                res.valid = 1'b1;
                if (rd_addr >= 8'(TABLE_SIZE)) begin
                  res.code = OP_FAIL;
                end else begin
                  res.code = OP_TABLE;
                  rd_en    = 1'b1;
                end
              end
            end
            PH_F2HI: begin
              res.valid = 1'b1;
              res.data  = pair35(pending_nibble, ch);
            end
            PH_F1LO: begin
              res.valid = 1'b1;
              res.data  = pending_nibble + cmd.hex;
            end
            PH_F1LIT: begin
              if (ch != CHAR_TILDE) begin
                res.valid = 1'b1;
                res.data  = ch;
              end
            end
            PH_F1STAR: begin
              if (ch != CHAR_STAR) begin
                res.valid = 1'b1;
                res.code  = OP_FAIL;
              end
            end
            PH_CHECK: begin
              if (check_last) begin
                res.valid = 1'b1;
                res.code  = OP_VERDICT;
                res.check = take_digit ? check_step : check_value;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Write and read the lookup table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      special_table[table_index] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= special_table[rd_addr];
    end
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      format_two     <= 1'b0;
      table_index    <= '0;
      pending_nibble <= '0;
      check_value    <= '0;
      digit_count    <= '0;
      digits_stopped <= 1'b0;
      pend_clr       <= 1'b0;
    end else begin
      phase          <= phase_next;
      format_two     <= format_two_next;
      table_index    <= table_index_next;
      pending_nibble <= pending_nibble_next;
      check_value    <= check_value_next;
      digit_count    <= digit_count_next;
      digits_stopped <= digits_stopped_next;
      pend_clr       <= pend_clr_next;
    end
  end

  `MPD_NEVER(a_op_stalled, res.valid && !out_ready, "operation issued while output busy")
  `MPD_ASSERT(a_table_done, (wr_en && table_index == 8'(TABLE_SIZE - 1)) |=> (phase == PH_F2DATA), "table load did not end")
  `MPD_NEVER(a_digit_over, phase == PH_CHECK && digit_count >= 3'(CHECK_DIGITS), "checksum digit count overran")

endmodule

>>> hw/rtl/mpd_out.sv
// ----------------------------------------------------------------------------
// Memo payload decoder output stage
// Holds one result transaction, keeps the part byte sum and judges the
// checksum against it.
// ----------------------------------------------------------------------------
module mpd_out (
  input  logic          clk,
  input  logic          rst,
  input  mpd_pkg::res_t res,
  input  logic [7:0]    rd_data,
  output logic          out_ready,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [1:0]    kind,
  output logic [7:0]    out_byte
);
  import mpd_pkg::*;

  logic                       held_valid;
  op_code_t                   held_code;
  logic [7:0]                 held_data;
  logic [CHECK_W-1:0]         held_check;
  logic                       held_clr;
  logic [15:0]                byte_sum;
  logic [15:0]                sum_base;
  logic [7:0]                 byte_val;
  logic                       is_byte;
  logic                       taken;
  kind_t                      kind_code;

  assign taken     = held_valid && !result_stall;
  assign out_ready = !held_valid || !result_stall;

  // Form the result from the held operation
  assign sum_base = held_clr ? 16'd0 : byte_sum;
  assign is_byte  = (held_code == OP_BYTE) || (held_code == OP_TABLE);
  assign byte_val = (held_code == OP_TABLE) ? rd_data : held_data;

  always_comb begin
    case (held_code)
      OP_BYTE, OP_TABLE: kind_code = KIND_BYTE;
      OP_VERDICT: kind_code = (held_check == CHECK_W'(sum_base)) ? KIND_GOOD : KIND_ERROR;
      default: kind_code = KIND_ERROR;
    endcase
  end

  assign result_valid = held_valid;
  assign kind         = kind_code;
  assign out_byte     = is_byte ? byte_val : 8'd0;

  // Load the next operation
  always_ff @(posedge clk) begin
    if (res.valid) begin
      held_code  <= res.code;
      held_data  <= res.data;
      held_check <= res.check;
      held_clr   <= res.clr;
    end
  end

  // Track occupancy and accumulate the byte sum on delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      byte_sum   <= '0;
    end else begin
      if (res.valid) begin
        held_valid <= 1'b1;
      end else if (taken) begin
        held_valid <= 1'b0;
      end
      if (taken) begin
        byte_sum <= sum_base + (is_byte ? {8'd0, byte_val} : 16'd0);
      end
    end
  end

endmodule

>>> hw/rtl/memo_payload_decoder.sv
// ----------------------------------------------------------------------------
// Memo payload decoder
// Decodes the text payload of upload parts into bytes and checks each part's
// decimal checksum against a 16-bit byte sum.
// ----------------------------------------------------------------------------
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------
//   item    | item_valid / item_stall    | action, in_char
//   result  | result_valid / result_stall| kind, out_byte
//
// One character per cycle sustained while neither stall holds the flow;
// a character passes through the queue entry and then the output register
// before its result_valid rises. Table lookups use a registered read of the
// 203-entry table memory, paired with the output register. Reset clears
// control state; the table is valid only once loaded. item_stall rises only
// when the command queue is full; result_stall holds the output register and
// then the sequencer, not the queue's inputs directly.
module memo_payload_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] action,
  input  logic [7:0] in_char,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte
);
  import mpd_pkg::*;

  cmd_t       cmd_in;
  cmd_t       cmd_head;
  logic       q_valid;
  logic       q_pop;
  logic       out_ready;
  res_t       res;
  logic [7:0] rd_data;

  // Classify incoming transactions
  mpd_front u_front (
    .action  (action),
    .in_char (in_char),
    .cmd     (cmd_in)
  );

  // Decouple front end from sequencer
  mpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (item_valid),
    .full       (item_stall),
    .push_data  (cmd_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (cmd_head)
  );

  // Run the part state machine
  mpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .cmd       (cmd_head),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .res       (res),
    .rd_data   (rd_data)
  );

  // Deliver results
  mpd_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .rd_data      (rd_data),
    .out_ready    (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_byte     (out_byte)
  );

endmodule
